### src/qcc_pkg.sv
// shared types and constants of the quadratic color correction block
// no dependencies; imported by qcc_channel, quadratic_color_correction and the testbench
package qcc_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned TERM_W      = 16;
  localparam int unsigned RAW_COEFF_W = 16;
  localparam int unsigned NUM_TERMS   = 10;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned NUM_COEFFS  = NUM_TERMS * NUM_CH;
  localparam int unsigned NUM_WORDS   = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned COEFFS_PER_WORD = 4;

  // term positions inside one channel's coefficient set
  localparam int unsigned TERM_R  = 0;
  localparam int unsigned TERM_G  = 1;
  localparam int unsigned TERM_B  = 2;
  localparam int unsigned TERM_RR = 3;
  localparam int unsigned TERM_GG = 4;
  localparam int unsigned TERM_BB = 5;
  localparam int unsigned TERM_RG = 6;
  localparam int unsigned TERM_GB = 7;
  localparam int unsigned TERM_BR = 8;
  localparam int unsigned TERM_K  = 9;

  // 255 * 255, weight of the constant term
  localparam logic [TERM_W-1:0] CONST_TERM = 16'd65025;
  // 255 * 256: first scaled sum whose quotient by 255 exceeds 255
  localparam int unsigned SAT_LIMIT = 65280;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [TERM_W-1:0] term_t;

  // load enables of the per-channel pipeline stages
  typedef struct packed {
    logic mul;
    logic part;
    logic total;
    logic div;
  } qcc_stage_en_t;

endpackage

### src/qcc_channel.sv
// one output channel: ten weighted products, adder tree, scale and saturate
// depends on qcc_pkg; stage enables come from quadratic_color_correction
module qcc_channel import qcc_pkg::*; #(
  parameter int unsigned COEFF_FRAC_BITS = 15
) (
  input  logic          clk_i,
  input  qcc_stage_en_t en_i,
  input  term_t         term_i [NUM_TERMS],
  input  logic [((COEFF_FRAC_BITS >= 16) ? 16 : COEFF_FRAC_BITS + 1)-1:0]
                        coeff_i [NUM_TERMS],
  output pixel_t        pix_o
);

  localparam int unsigned CW  = (COEFF_FRAC_BITS >= 16) ? 16 : COEFF_FRAC_BITS + 1;
  localparam int unsigned PW  = CW + TERM_W;
  localparam int unsigned PSW = PW + 3;
  localparam int unsigned NW  = PW + 4;
  localparam int unsigned HALF = NUM_TERMS / 2;

  logic [PW-1:0]  prod_q [NUM_TERMS];
  logic [PSW-1:0] part_d [2];
  logic [PSW-1:0] part_q [2];
  logic [NW-1:0]  total;
  logic [NW-1:0]  scaled;
  logic           sat_q;
  logic [15:0]    m_q;
  logic [16:0]    m_inc;
  logic [24:0]    recip;
  pixel_t         pix_q;

  // products, one multiplier per term
  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      for (int t = 0; t < NUM_TERMS; t++) begin
        prod_q[t] <= PW'(coeff_i[t]) * PW'(term_i[t]);
      end
    end
  end

  always_comb begin
    part_d[0] = '0;
    part_d[1] = '0;
    for (int t = 0; t < HALF; t++) begin
      part_d[0] = part_d[0] + PSW'(prod_q[t]);
      part_d[1] = part_d[1] + PSW'(prod_q[t + HALF]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.part) begin
      part_q <= part_d;
    end
  end

  // drop the fraction bits, flag a quotient above 255
  assign total  = NW'(part_q[0]) + NW'(part_q[1]);
  assign scaled = total >> COEFF_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i.total) begin
      sat_q <= (scaled >= NW'(SAT_LIMIT));
      m_q   <= scaled[15:0];
    end
  end

  // floor(m / 255) = ((m + 1) * 257) >> 16, exact below the saturation limit
  assign m_inc = {1'b0, m_q} + 17'd1;
  assign recip = {m_inc, 8'b0} + 25'(m_inc);

  always_ff @(posedge clk_i) begin
    if (en_i.div) begin
      pix_q <= sat_q ? '1 : recip[23:16];
    end
  end

  assign pix_o = pix_q;

endmodule

### src/quadratic_color_correction.sv
// top level of the quadratic color correction block
// depends on qcc_pkg and qcc_channel
//
// usage
// - input channel: in_valid_i / in_ready_o with red_in_i, green_in_i, blue_in_i;
//   a pixel transfers when valid and ready are both high
// - output channel: out_valid_o / out_ready_i with red_out_o, green_out_o,
//   blue_out_o; one corrected pixel per input pixel, in order
// - coefficients: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
//   clock edge; write only while no pixel is in flight
// - pipeline: an input transfer passes through the registered stages terms,
//   products, partial sums, scale and divide by 255 before its result shows
//   on the output
// - throughput: one pixel per clock unless the receiver stalls, set by the
//   five-stage pipeline with one multiplier per term and channel
// - reset: pipeline empties, coefficients return to identity
// - receiver stall: each stage holds while the stage after it is full and
//   stalled; empty stages still fill, so ready drops only when all five hold
module quadratic_color_correction import qcc_pkg::*; #(
  parameter int unsigned COEFF_FRAC_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      red_in_i,
  input  logic [PIX_W-1:0]      green_in_i,
  input  logic [PIX_W-1:0]      blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      red_out_o,
  output logic [PIX_W-1:0]      green_out_o,
  output logic [PIX_W-1:0]      blue_out_o
);

  // clamped coefficient width: 1.0 needs one bit above the fraction
  localparam int unsigned CW = (COEFF_FRAC_BITS >= 16) ? 16 : COEFF_FRAC_BITS + 1;
  localparam int unsigned NUM_STAGES = 5;
  localparam logic [24:0] ONE_VAL = 25'(1) << COEFF_FRAC_BITS;
  localparam logic [24:0] RAW_ONE = 25'd32768;
  // reset value 0x8000, as stored after clamping
  localparam logic [24:0] RESET_ONE_W = (RAW_ONE > ONE_VAL) ? ONE_VAL : RAW_ONE;
  localparam logic [CW-1:0] RESET_ONE = RESET_ONE_W[CW-1:0];

  // identity coefficients: red r, green g, blue b
  localparam int unsigned RESET_RED   = TERM_R;
  localparam int unsigned RESET_GREEN = NUM_TERMS + TERM_G;
  localparam int unsigned RESET_BLUE  = 2 * NUM_TERMS + TERM_B;

  logic [CW-1:0] coeff_q [NUM_COEFFS];

  // ---------------------------------------------------------------------
  // coefficient registers, clamped to 1.0 as they are written
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_coeff
    localparam int unsigned WORD = k / COEFFS_PER_WORD;
    localparam int unsigned LSB  = RAW_COEFF_W * (k % COEFFS_PER_WORD);
    localparam logic [CW-1:0] RST_VAL =
      (k == RESET_RED || k == RESET_GREEN || k == RESET_BLUE) ? RESET_ONE : '0;

    logic [24:0]   raw_w;
    logic [24:0]   clamp_w;

    assign raw_w   = 25'(cfg_wdata_i[LSB +: RAW_COEFF_W]);
    assign clamp_w = (raw_w > ONE_VAL) ? ONE_VAL : raw_w;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        coeff_q[k] <= RST_VAL;
      end else if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(WORD))) begin
        coeff_q[k] <= clamp_w[CW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or the next one loads
  // ---------------------------------------------------------------------
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] load;
  qcc_stage_en_t         stage_en;

  always_comb begin
    load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      load[s] = !valid_q[s] || load[s + 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (load[s]) begin
          valid_q[s] <= valid_q[s - 1];
        end
      end
    end
  end

  assign stage_en.mul   = load[1];
  assign stage_en.part  = load[2];
  assign stage_en.total = load[3];
  assign stage_en.div   = load[4];

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  // ---------------------------------------------------------------------
  // stage 1: linear, square and cross terms shared by all three channels
  // ---------------------------------------------------------------------
  term_t term_q [NUM_TERMS];
  term_t term_d [NUM_TERMS];
  term_t red_w;
  term_t green_w;
  term_t blue_w;

  assign red_w   = TERM_W'(red_in_i);
  assign green_w = TERM_W'(green_in_i);
  assign blue_w  = TERM_W'(blue_in_i);

  always_comb begin
    // 255 * p written as 256 * p - p
    term_d[TERM_R]  = (red_w << 8) - red_w;
    term_d[TERM_G]  = (green_w << 8) - green_w;
    term_d[TERM_B]  = (blue_w << 8) - blue_w;
    term_d[TERM_RR] = red_w * red_w;
    term_d[TERM_GG] = green_w * green_w;
    term_d[TERM_BB] = blue_w * blue_w;
    term_d[TERM_RG] = red_w * green_w;
    term_d[TERM_GB] = green_w * blue_w;
    term_d[TERM_BR] = blue_w * red_w;
    term_d[TERM_K]  = CONST_TERM;
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      term_q <= term_d;
    end
  end

  // ---------------------------------------------------------------------
  // stages 2 to 5: one channel unit per output color
  // ---------------------------------------------------------------------
  pixel_t ch_pix [NUM_CH];

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [CW-1:0] ch_coeff [NUM_TERMS];

    for (genvar t = 0; t < NUM_TERMS; t++) begin : g_sel
      assign ch_coeff[t] = coeff_q[c * NUM_TERMS + t];
    end

    qcc_channel #(
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_channel (
      .clk_i   (clk_i),
      .en_i    (stage_en),
      .term_i  (term_q),
      .coeff_i (ch_coeff),
      .pix_o   (ch_pix[c])
    );
  end

  assign red_out_o   = ch_pix[0];
  assign green_out_o = ch_pix[1];
  assign blue_out_o  = ch_pix[2];

endmodule

### bench/quadratic_color_correction_tb.sv
// self-checking testbench of quadratic_color_correction: directed and random pixels
// depends on qcc_pkg and the quadratic_color_correction rtl
`timescale 1ns / 1ps

module quadratic_color_correction_tb import qcc_pkg::*; ();

  localparam int unsigned COEFF_FRAC_BITS = 15;
  // 1.0 in the coefficient fixed point format
  localparam logic [RAW_COEFF_W-1:0] COEFF_ONE = RAW_COEFF_W'(1) << COEFF_FRAC_BITS;
  // input transfer to the earliest output transfer
  localparam int unsigned PIPE_LATENCY = 5;
  localparam int unsigned DRAIN_CYCLES = 2 * PIPE_LATENCY;
  // cycles with no transfer on either channel before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES = 9;
  localparam int unsigned PIXELS_PER_PHASE = 104;

  typedef struct packed {
    pixel_t red;
    pixel_t green;
    pixel_t blue;
  } rgb_t;

  // keeps a copy of the coefficient words, predicts each corrected pixel
  // and compares the output transfers against it in order
  class correction_scoreboard;
    logic [CFG_DATA_W-1:0] coeff_words [NUM_WORDS];
    rgb_t expected_pixels [$];
    int error_count;

    function new();
      foreach (coeff_words[i]) coeff_words[i] = '0;
      // identity after reset
      coeff_words[0] = 64'd32768;
      coeff_words[2] = 64'd1 << 63;
      coeff_words[5] = 64'd1 << 47;
      error_count = 0;
    endfunction

    function void set_word(int unsigned idx, logic [CFG_DATA_W-1:0] word);
      coeff_words[idx] = word;
      // only the low half of the last word holds coefficients
      if (idx == NUM_WORDS - 1) coeff_words[idx][63:32] = '0;
    endfunction

    function bit [63:0] clamped_coeff(int unsigned k);
      bit [63:0] field;
      field = 64'(coeff_words[k / COEFFS_PER_WORD]
                             [RAW_COEFF_W*(k % COEFFS_PER_WORD) +: RAW_COEFF_W]);
      return (field > 64'(COEFF_ONE)) ? 64'(COEFF_ONE) : field;
    endfunction

    function pixel_t corrected_channel(int unsigned base, pixel_t r8, pixel_t g8, pixel_t b8);
      bit [63:0] r, g, b, acc, quot;
      r = 64'(r8);
      g = 64'(g8);
      b = 64'(b8);
      acc = 64'd255 * (clamped_coeff(base + TERM_R) * r + clamped_coeff(base + TERM_G) * g +
                       clamped_coeff(base + TERM_B) * b);
      acc += clamped_coeff(base + TERM_RR) * (r * r);
      acc += clamped_coeff(base + TERM_GG) * (g * g);
      acc += clamped_coeff(base + TERM_BB) * (b * b);
      acc += clamped_coeff(base + TERM_RG) * (r * g);
      acc += clamped_coeff(base + TERM_GB) * (g * b);
      acc += clamped_coeff(base + TERM_BR) * (b * r);
      acc += 64'd65025 * clamped_coeff(base + TERM_K);
      quot = acc / (64'd255 << COEFF_FRAC_BITS);
      return (quot > 64'd255) ? 8'd255 : quot[PIX_W-1:0];
    endfunction

    function void note_pixel(pixel_t r, pixel_t g, pixel_t b);
      rgb_t px;
      px.red   = corrected_channel(0, r, g, b);
      px.green = corrected_channel(NUM_TERMS, r, g, b);
      px.blue  = corrected_channel(2 * NUM_TERMS, r, g, b);
      expected_pixels.push_back(px);
    endfunction

    function void check_pixel(pixel_t r, pixel_t g, pixel_t b);
      rgb_t px;
      if (expected_pixels.size() == 0) begin
        $error("output transfer with no pixel pending: %0d %0d %0d", r, g, b);
        error_count++;
        return;
      end
      px = expected_pixels.pop_front();
      if (r !== px.red) begin
        $error("red_out: expected %0d, got %0d", px.red, r);
        error_count++;
      end
      if (g !== px.green) begin
        $error("green_out: expected %0d, got %0d", px.green, g);
        error_count++;
      end
      if (b !== px.blue) begin
        $error("blue_out: expected %0d, got %0d", px.blue, b);
        error_count++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      red_in_i;
  logic [PIX_W-1:0]      green_in_i;
  logic [PIX_W-1:0]      blue_in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PIX_W-1:0]      red_out_o;
  logic [PIX_W-1:0]      green_out_o;
  logic [PIX_W-1:0]      blue_out_o;

  // percent of cycles in which each side holds back
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // coefficient words staged for the next load
  logic [CFG_DATA_W-1:0] next_words [NUM_WORDS];
  correction_scoreboard sb;

  quadratic_color_correction #(
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // place one raw coefficient field into the staged words
  function void put_coeff(int unsigned k, logic [RAW_COEFF_W-1:0] value);
    next_words[k / COEFFS_PER_WORD][RAW_COEFF_W*(k % COEFFS_PER_WORD) +: RAW_COEFF_W] = value;
  endfunction

  function void clear_words();
    foreach (next_words[i]) next_words[i] = '0;
  endfunction

  // mostly in range up to limit, with exact zero, exact one and clamped fields mixed in
  function logic [RAW_COEFF_W-1:0] random_field(int unsigned limit);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return COEFF_ONE;
      2:       return RAW_COEFF_W'($urandom_range(COEFF_ONE + 1, 16'hFFFF));
      default: return RAW_COEFF_W'($urandom_range(0, limit));
    endcase
  endfunction

  // samples lean toward the extremes now and then
  function pixel_t random_sample();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // all calls start right after a rising edge; valid stays high on return so
  // back-to-back pixels never drop it in between
  task automatic send_pixel(pixel_t r, pixel_t g, pixel_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(r, g, b);
  endtask

  // stop sending and let every pixel in flight come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write every staged word, one per cycle; only called with the pipe empty
  task automatic load_coeffs();
    for (int unsigned i = 0; i < NUM_WORDS; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(i);
      cfg_wdata_i <= next_words[i];
      @(posedge clk_i);
      sb.set_word(i, next_words[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // receiver: check each output transfer, then pick the next ready
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_pixel(red_out_o, green_out_o, blue_out_o);
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: counts cycles in which neither channel moves a transfer
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("quadratic_color_correction test failed");
    $finish;
  end

  initial begin
    int unsigned limit;
    sb = new();
    send_idle_pct = 17;
    recv_idle_pct = 62;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    red_in_i    <= '0;
    green_in_i  <= '0;
    blue_in_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // identity after reset: output equals input
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_pixel(8'd1, 8'd254, 8'd127);

    // every field all ones: clamps to 1.0 and the sum saturates
    wait_drained();
    foreach (next_words[i]) next_words[i] = '1;
    load_coeffs();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);

    // constant one step below 1.0 lands at 254, junk in the unused top of the last word
    wait_drained();
    clear_words();
    for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
      put_coeff(ch * NUM_TERMS + TERM_K, RAW_COEFF_W'(COEFF_ONE - 1));
    end
    next_words[NUM_WORDS-1][63:32] = 32'hA5A5_5A5A;
    load_coeffs();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);

    // square and cross terms, blue overflows past 255
    wait_drained();
    clear_words();
    put_coeff(TERM_RR, COEFF_ONE);
    put_coeff(NUM_TERMS + TERM_GB, COEFF_ONE);
    put_coeff(2 * NUM_TERMS + TERM_BR, COEFF_ONE);
    put_coeff(2 * NUM_TERMS + TERM_RG, COEFF_ONE >> 1);
    put_coeff(NUM_TERMS + TERM_K, RAW_COEFF_W'(COEFF_ONE + 1));
    load_coeffs();
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd16, 8'd16, 8'd16);
    send_pixel(8'd128, 8'd64, 8'd32);
    send_pixel(8'd0, 8'd255, 8'd0);

    // all coefficients zero
    wait_drained();
    clear_words();
    load_coeffs();
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd1);

    // random phases: idle pattern rotates every three, fresh coefficients each time
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_drained();
      case ($urandom_range(0, 3))
        0:       limit = 2048;
        1:       limit = 8192;
        2:       limit = 32'(COEFF_ONE);
        default: limit = 16'hFFFF;
      endcase
      for (int unsigned k = 0; k < NUM_COEFFS; k++) put_coeff(k, random_field(limit));
      next_words[NUM_WORDS-1][63:32] = $urandom();
      load_coeffs();
      for (int unsigned n = 0; n < PIXELS_PER_PHASE; n++) begin
        send_pixel(random_sample(), random_sample(), random_sample());
        // sender holds off until the pipe has emptied completely
        if (phase == 0 && n == PIXELS_PER_PHASE / 2) wait_drained();
      end
    end

    wait_drained();
    if (sb.expected_pixels.size() != 0) begin
      $error("%0d pixels never came out", sb.expected_pixels.size());
      sb.error_count++;
    end
    if (sb.error_count == 0) begin
      $display("quadratic_color_correction test passed");
    end else begin
      $display("quadratic_color_correction test failed");
    end
    $finish;
  end

endmodule
